### hdl/mkp_pkg.sv
// Shared types, constants and the key code table for the keypad scanner.
// No dependencies; used by the lane, merge and top-level modules.
package mkp_pkg;

  localparam int ROW_COUNT = 6;
  localparam int COLUMN_COUNT = 4;
  localparam int ROW_W = 3;
  localparam int COL_W = 2;
  localparam int CODE_W = 8;
  localparam int COUNT_W = 8;
  localparam int DRIVE_W = 4;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [COUNT_W-1:0] THRESHOLD_RESET = 8'd3;
  localparam logic [0:0] REG_PRESS_THRESHOLD = 1'b0;

  localparam logic [CODE_W-1:0] KEY_TABLE [ROW_COUNT][COLUMN_COUNT] = '{
    '{"#", "9", "6", "3"},
    '{"0", "8", "5", "2"},
    '{"*", "7", "4", "1"},
    '{"R", "q", "U", "D"},
    '{"Q", "L", "e", "d"},
    '{"c", "b", "a", "d"}
  };

  typedef struct packed {
    logic               tick;
    logic [COL_W-1:0]   column;
    logic [COUNT_W-1:0] threshold;
  } lane_ctrl_t;

  typedef struct packed {
    logic               key_event;
    logic [CODE_W-1:0]  key_code;
    logic [ROW_W-1:0]   key_row;
    logic [COL_W-1:0]   key_column;
    logic [DRIVE_W-1:0] column_drive;
  } result_t;

endpackage

### hdl/matrix_keypad_scan_debounce_core.sv
// Top level of the 6 x 4 keypad scanner with per-key debounce.
// Depends on mkp_pkg, mkp_lane and mkp_merge.
//
// Usage: each input transaction (in_valid, in_stall, row_levels) carries the
// row levels sampled while the current column is driven. Every transaction
// yields exactly one output transaction (out_valid, out_stall) with the
// release event, its code, row and column, and the one-hot drive for the next
// column, which the system applies before taking the next sample.
// Six row lanes update their counters for the current column in the cycle of
// acceptance; the merge picks the highest releasing row. The result is
// registered; one transaction is taken every cycle while in_stall is low. A
// second output register absorbs one transaction while the receiver stalls,
// so in_stall rises only when both are full. The press threshold is written
// over the APB-style port where paddr[2] is 0; the user must do so only while
// idle; the block does not enforce it. Reset clears all counters, the column
// index (column 0 is scanned first) and valid flags; the threshold becomes 3.
module matrix_keypad_scan_debounce_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [mkp_pkg::ROW_COUNT-1:0] row_levels,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          key_event,
  output logic [mkp_pkg::CODE_W-1:0]    key_code,
  output logic [mkp_pkg::ROW_W-1:0]     key_row,
  output logic [mkp_pkg::COL_W-1:0]     key_column,
  output logic [mkp_pkg::DRIVE_W-1:0]   column_drive,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mkp_pkg::PADDR_W-1:0]   paddr,
  input  logic [mkp_pkg::PDATA_W-1:0]   pwdata,
  output logic [mkp_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  logic [mkp_pkg::COUNT_W-1:0]   press_threshold;
  logic [mkp_pkg::COL_W-1:0]     column_index;
  logic [mkp_pkg::COL_W-1:0]     column_index_next;
  logic [mkp_pkg::DRIVE_W-1:0]   drive_next;
  logic [mkp_pkg::ROW_COUNT-1:0] releases;
  logic                          accept;
  logic                          take;
  logic                          skid_valid;
  mkp_pkg::lane_ctrl_t           ctrl;
  mkp_pkg::result_t              result;
  mkp_pkg::result_t              out_data;
  mkp_pkg::result_t              skid_data;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == mkp_pkg::REG_PRESS_THRESHOLD) ?
                  mkp_pkg::PDATA_W'(press_threshold) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      press_threshold <= mkp_pkg::THRESHOLD_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == mkp_pkg::REG_PRESS_THRESHOLD) begin
      press_threshold <= pwdata[mkp_pkg::COUNT_W-1:0];
    end
  end

  assign in_stall = skid_valid;
  assign accept = in_valid && !in_stall;
  assign take = out_valid && !out_stall;

  assign column_index_next = (column_index == mkp_pkg::COL_W'(mkp_pkg::COLUMN_COUNT - 1)) ?
                             '0 : column_index + 1'b1;
  assign drive_next = mkp_pkg::DRIVE_W'(1) << column_index_next;

  assign ctrl.tick = accept;
  assign ctrl.column = column_index;
  assign ctrl.threshold = press_threshold;

  for (genvar r = 0; r < mkp_pkg::ROW_COUNT; r++) begin : g_lane
    mkp_lane u_lane (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .level       (row_levels[r]),
      .release_hit (releases[r])
    );
  end

  mkp_merge u_merge (
    .releases (releases),
    .column   (column_index),
    .drive    (drive_next),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      column_index <= '0;
    end else if (accept) begin
      column_index <= column_index_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || take) begin
      if (skid_valid) begin
        out_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || take) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (accept) begin
        out_data <= result;
      end
    end else if (accept) begin
      skid_data <= result;
    end
  end

  assign key_event = out_data.key_event;
  assign key_code = out_data.key_code;
  assign key_row = out_data.key_row;
  assign key_column = out_data.key_column;
  assign column_drive = out_data.column_drive;

  a_skid_behind_out : assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds a transaction while the output is empty");

  a_column_steps : assert property (@(posedge clk) disable iff (rst)
    accept |=> column_index == $past(column_index_next))
    else $error("column index did not advance on an accepted transaction");

  a_idle_fields_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && !key_event |-> key_code == '0 && key_row == '0 && key_column == '0)
    else $error("key fields not cleared for a tick without release");

  a_drive_onehot : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot(column_drive))
    else $error("column drive is not one-hot");

endmodule

### hdl/mkp_lane.sv
// One row lane: the debounce counters of every key in one row of the matrix.
// Depends on mkp_pkg for widths and the lane control struct.
module mkp_lane (
  input  logic                clk,
  input  logic                rst,
  input  mkp_pkg::lane_ctrl_t ctrl,
  input  logic                level,
  output logic                release_hit
);

  logic [mkp_pkg::COUNT_W-1:0] counts [mkp_pkg::COLUMN_COUNT];
  logic [mkp_pkg::COUNT_W-1:0] count;
  logic [mkp_pkg::COUNT_W-1:0] count_next;

  assign count = counts[ctrl.column];
  assign release_hit = !level && (count >= ctrl.threshold);

  always_comb begin
    if (level) begin
      if (count < ctrl.threshold) begin
        count_next = count + 1'b1;
      end else begin
        count_next = count;
      end
    end else begin
      count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < mkp_pkg::COLUMN_COUNT; c++) begin
        counts[c] <= '0;
      end
    end else if (ctrl.tick) begin
      counts[ctrl.column] <= count_next;
    end
  end

endmodule

### hdl/mkp_merge.sv
// Merges the lane release flags: the highest releasing row wins, and its code
// is looked up. Depends on mkp_pkg for the key table and the result struct.
module mkp_merge (
  input  logic [mkp_pkg::ROW_COUNT-1:0] releases,
  input  logic [mkp_pkg::COL_W-1:0]     column,
  input  logic [mkp_pkg::DRIVE_W-1:0]   drive,
  output mkp_pkg::result_t              result
);

  always_comb begin
    result = '0;
    result.column_drive = drive;
    for (int r = 0; r < mkp_pkg::ROW_COUNT; r++) begin
      if (releases[r]) begin
        result.key_event = 1'b1;
        result.key_row = mkp_pkg::ROW_W'(r);
        result.key_column = column;
        result.key_code = mkp_pkg::KEY_TABLE[r][column];
      end
    end
  end

endmodule
